### rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants and the queue entry type of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_BITS   = 4;
    localparam int CAP_BITS   = 5;
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = 32;
    localparam int RANK_BITS  = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(ENTRIES);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One accepted request as it waits between front and back end.
    typedef struct packed {
        logic                       opcode;
        logic signed [KEY_BITS-1:0] lookup_key;
        logic signed [KEY_BITS-1:0] store_value;
    } req_t;

endpackage

### rtl/lfu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache front end
// Accepts request transfers and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lfu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lfu_pkg::req_t s_req,
    output logic          q_valid,
    input  logic          q_ready,
    output lfu_pkg::req_t q_req
);

    lfu_pkg::req_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_req;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !s_tready) else $error("queue overflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0) else $error("pop from empty queue");

endmodule

### rtl/lfu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache back end
// Looks up, selects a victim and updates the table; one result per request.
// ----------------------------------------------------------------------------
module lfu_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lfu_pkg::CAP_BITS-1:0]      cap_cfg,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  lfu_pkg::req_t                     q_req,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} state_t;

    state_t state_reg;
    lfu_pkg::req_t req_reg;

    logic [lfu_pkg::ENTRIES-1:0]          valid_reg;
    logic signed [lfu_pkg::KEY_BITS-1:0]  key_reg   [lfu_pkg::ENTRIES];
    logic signed [lfu_pkg::KEY_BITS-1:0]  value_reg [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0]       count_reg [lfu_pkg::ENTRIES];
    logic [lfu_pkg::RANK_BITS-1:0]        rank_reg  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::CAP_BITS-1:0]         occ_reg;

    logic                          o_hit_reg, o_ev_reg;
    logic signed [31:0]            o_rd_reg, o_evk_reg;

    logic                          hit_c, vfound_c;
    logic [lfu_pkg::IDX_BITS-1:0]  hidx_c, vidx_c, free_c;
    logic [lfu_pkg::CAP_BITS-1:0]  cap_c;

    // Victim search tree: node n holds the better of nodes 2n and 2n+1.
    logic [2*lfu_pkg::ENTRIES-1:0] node_v;
    logic [lfu_pkg::IDX_BITS-1:0]  node_i [2*lfu_pkg::ENTRIES];
    logic [lfu_pkg::IDX_BITS-1:0]  left_c, right_c;

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, o_evk_reg, o_ev_reg, o_rd_reg, o_hit_reg};
    assign cap_c    = (cap_cfg > lfu_pkg::CAP_RESET) ? lfu_pkg::CAP_RESET : cap_cfg;

    // Parallel key compare and free slot search.
    always_comb begin
        hit_c    = 1'b0;
        hidx_c   = '0;
        free_c   = '0;
        for (int j = lfu_pkg::ENTRIES - 1; j >= 0; j--) begin
            if (valid_reg[j] && key_reg[j] == req_reg.lookup_key) begin
                hit_c  = 1'b1;
                hidx_c = lfu_pkg::IDX_BITS'(j);
            end
            if (!valid_reg[j]) begin
                free_c = lfu_pkg::IDX_BITS'(j);
            end
        end
    end

    // Lowest count, then oldest rank, picked by a balanced compare tree.
    // Ranks of valid entries are distinct, so the winner is unique.
    always_comb begin
        node_v[0] = 1'b0;
        node_i[0] = '0;
        left_c    = '0;
        right_c   = '0;
        for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
            node_v[lfu_pkg::ENTRIES + j] = valid_reg[j];
            node_i[lfu_pkg::ENTRIES + j] = lfu_pkg::IDX_BITS'(j);
        end
        for (int n = lfu_pkg::ENTRIES - 1; n >= 1; n--) begin
            left_c  = node_i[2*n];
            right_c = node_i[2*n+1];
            if (node_v[2*n] && (!node_v[2*n+1] || count_reg[left_c] < count_reg[right_c] ||
                (count_reg[left_c] == count_reg[right_c] &&
                 rank_reg[left_c] > rank_reg[right_c]))) begin
                node_i[n] = left_c;
            end else begin
                node_i[n] = right_c;
            end
            node_v[n] = node_v[2*n] | node_v[2*n+1];
        end
        vfound_c = node_v[1];
        vidx_c   = node_i[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            occ_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        req_reg   <= q_req;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg  <= ST_OUT;
                    o_hit_reg  <= hit_c;
                    o_rd_reg   <= '0;
                    o_ev_reg   <= 1'b0;
                    o_evk_reg  <= '0;
                    if (hit_c) begin
                        // Touch: promote to most recent and bump the count.
                        // A put with zero capacity leaves the table alone.
                        if (req_reg.opcode == lfu_pkg::OP_GET || cap_c != '0) begin
                            for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
                                if (valid_reg[j] && rank_reg[j] < rank_reg[hidx_c]) begin
                                    rank_reg[j] <= rank_reg[j] + 1'b1;
                                end
                            end
                            rank_reg[hidx_c] <= '0;
                            if (count_reg[hidx_c] != lfu_pkg::COUNT_MAX) begin
                                count_reg[hidx_c] <= count_reg[hidx_c] + 1'b1;
                            end
                        end
                        if (req_reg.opcode == lfu_pkg::OP_GET) begin
                            o_rd_reg <= value_reg[hidx_c];
                        end else if (cap_c != '0) begin
                            value_reg[hidx_c] <= req_reg.store_value;
                        end
                    end else if (req_reg.opcode == lfu_pkg::OP_PUT && cap_c != '0) begin
                        if (occ_reg >= cap_c && vfound_c) begin
                            // Evict and insert in the victim's slot.
                            o_ev_reg  <= 1'b1;
                            o_evk_reg <= key_reg[vidx_c];
                            for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
                                if (valid_reg[j] && rank_reg[j] < rank_reg[vidx_c]) begin
                                    rank_reg[j] <= rank_reg[j] + 1'b1;
                                end
                            end
                            key_reg[vidx_c]   <= req_reg.lookup_key;
                            value_reg[vidx_c] <= req_reg.store_value;
                            count_reg[vidx_c] <= lfu_pkg::COUNT_BITS'(1);
                            rank_reg[vidx_c]  <= '0;
                        end else begin
                            for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
                                if (valid_reg[j]) begin
                                    rank_reg[j] <= rank_reg[j] + 1'b1;
                                end
                            end
                            valid_reg[free_c] <= 1'b1;
                            key_reg[free_c]   <= req_reg.lookup_key;
                            value_reg[free_c] <= req_reg.store_value;
                            count_reg[free_c] <= lfu_pkg::COUNT_BITS'(1);
                            rank_reg[free_c]  <= '0;
                            occ_reg           <= occ_reg + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= lfu_pkg::CAP_RESET) else $error("occupancy overflow");
    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == lfu_pkg::CAP_BITS'($countones(valid_reg)))
        else $error("occupancy mismatch");
    a_ev_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_ev_reg |-> !o_hit_reg) else $error("eviction on hit");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

endmodule

### rtl/lfu_cache_table_top.sv
`timescale 1ns / 1ps
// Each request passes the queue, then the back end's accept, update and result states.
// The back end takes no new request until the last result is taken by the receiver.
// A two-entry request queue keeps the input open while a result waits.
// Reset (aresetn low, synchronous): table empty, capacity 16, no result pending.
// ----------------------------------------------------------------------------
// LFU cache table top
// LFU key/value cache with least-recent tie break on eviction.
// ----------------------------------------------------------------------------
module lfu_cache_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // opcode, lookup_key, store_value, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // hit, read_value, evicted, evicted_key, zero pad
);

    logic [lfu_pkg::CAP_BITS-1:0] cap_reg;
    lfu_pkg::req_t s_req, q_req;
    logic q_valid, q_ready;

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign s_req.opcode      = s_tdata[0];
    assign s_req.lookup_key  = s_tdata[32:1];
    assign s_req.store_value = s_tdata[64:33];

    lfu_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_req(s_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    lfu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cap_cfg(cap_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
